[design/ptp_pkg.sv]
// Package for the packed-to-planar writer: screen geometry, widths,
// the group hand-off type and the plane gather function. No dependencies.
`default_nettype none

package ptp_pkg;

	localparam int SCREEN_WIDTH   = 640;
	localparam int SCREEN_HEIGHT  = 480;
	localparam int GROUPS_PER_ROW = SCREEN_WIDTH / 8;
	localparam int GROUP_COUNT    = GROUPS_PER_ROW * SCREEN_HEIGHT;
	localparam int IDX_W          = $clog2(GROUP_COUNT);

	localparam int ROW_W   = 9;
	localparam int COL_W   = 7;
	localparam int PIX_W   = 32;
	localparam int VOFF_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int PLANES  = 4;
	localparam int PLANE_W = 2;

	// one group that must be written out, lookup -> emit
	typedef struct packed {
		logic [VOFF_W-1:0] offset;
		logic [PIX_W-1:0]  pixels;
	} ptp_group_t;

	// bit 'plane' of each of the eight nibbles, leftmost pixel in bit 7
	function automatic logic [BYTE_W-1:0] gather_plane(input logic [PIX_W-1:0] grp,
			input logic [PLANE_W-1:0] plane);
		logic [BYTE_W-1:0] b;
		logic [3:0]        nib;
		b = '0;
		for (int k = 0; k < 8; k++) begin
			nib = grp[PIX_W-1-4*k -: 4];
			b[7-k] = nib[plane];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

[design/packed_to_planar_vga_writer_top.sv]
// Top level of the packed-to-planar writer: lookup stage and plane sequencer.
// Depends on ptp_pkg, ptp_lookup, ptp_emit (and ptp_ram through ptp_lookup).
//
// Takes groups of eight 4-bit packed pixels with their row and column group
// and turns each changed group into four plane writes (plane 0 first) at
// offset row*80+column_group, the byte holding bit p of the eight pixels with
// the leftmost pixel in bit 7; last_write marks plane 3. A 38400 x 32 cache
// RAM remembers the last group written at every position; a group equal to
// its cache entry is dropped unless force_write is set, and a position off
// screen is accepted and dropped. After reset the block clears the cache,
// one entry a cycle, and holds in_ready low until all 38400 entries are clear.
// Rate: unchanged and off-screen groups stream at one per cycle unless a
// changed group waits in the lookup stage; a changed group costs four plane
// writes, set by the single output port moving one plane write per transfer.
// The plane sequencer holds one group while the lookup stage holds the next;
// unchanged groups keep moving while writes drain. A changed group passes the
// lookup stage and sequencer registers before its first plane write. Groups at
// the same position back to back forward the entry just written into the
// compare, since the cache read returns the contents before that write.
`default_nettype none

module packed_to_planar_vga_writer_top
	import ptp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [ROW_W-1:0]   row,
	input  wire logic [COL_W-1:0]   column_group,
	input  wire logic [PIX_W-1:0]   pixels,
	input  wire logic               force_write,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [PLANE_W-1:0]      plane_index,
	output logic [VOFF_W-1:0]       video_offset,
	output logic [BYTE_W-1:0]       plane_bits,
	output logic                    last_write
);

	// changed group handed from lookup to the plane sequencer
	logic       grp_valid;
	logic       grp_ready;
	ptp_group_t grp;

	ptp_lookup u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.row         (row),
		.column_group(column_group),
		.pixels      (pixels),
		.force_write (force_write),
		.grp_valid   (grp_valid),
		.grp_ready   (grp_ready),
		.grp         (grp)
	);

	ptp_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.grp_valid   (grp_valid),
		.grp_ready   (grp_ready),
		.grp         (grp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.plane_index (plane_index),
		.video_offset(video_offset),
		.plane_bits  (plane_bits),
		.last_write  (last_write)
	);

endmodule

`default_nettype wire

[design/ptp_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Read of the address written in the same cycle returns the old contents.
`default_nettype none

module ptp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[design/ptp_lookup.sv]
// Cache lookup: offset calc, cache read, compare, write-back with forwarding,
// and the clearing pass after reset. Uses ptp_pkg and ptp_ram.
`default_nettype none

module ptp_lookup
	import ptp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [ROW_W-1:0] row,
	input  wire logic [COL_W-1:0] column_group,
	input  wire logic [PIX_W-1:0] pixels,
	input  wire logic             force_write,
	output logic                  grp_valid,
	input  wire logic             grp_ready,
	output ptp_group_t            grp
);

	// clearing pass
	logic             clr_q;
	logic [IDX_W-1:0] clr_addr_q;

	// lookup stage (cache read in flight / returned)
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PIX_W-1:0] pixels_s1;
	logic             redraw_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_data_s1;

	logic             accept;
	logic             in_range;
	logic [IDX_W-1:0] idx_s0;
	logic [PIX_W-1:0] rd_data;
	logic [PIX_W-1:0] cached;
	logic             emit_s1;
	logic             s1_adv;
	logic             s1_write;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [PIX_W-1:0] wr_data;

	assign in_range = (32'(row) < 32'(SCREEN_HEIGHT)) &&
		(32'(column_group) < 32'(GROUPS_PER_ROW));
	assign idx_s0 = IDX_W'(row) * IDX_W'(GROUPS_PER_ROW) + IDX_W'(column_group);

	// entry written as this entry's cache read was issued is not in rd_data: use fwd copy
	assign cached   = fwd_s1 ? fwd_data_s1 : rd_data;
	assign emit_s1  = redraw_s1 || (cached != pixels_s1);
	assign s1_adv   = valid_s1 && (!emit_s1 || grp_ready);
	assign s1_write = valid_s1 && emit_s1 && grp_ready;

	assign in_ready = !clr_q && (!valid_s1 || s1_adv);
	assign accept   = in_valid && in_ready;

	assign wr_en   = clr_q || s1_write;
	assign wr_addr = clr_q ? clr_addr_q : idx_s1;
	assign wr_data = clr_q ? '0 : pixels_s1;

	ptp_ram #(
		.WIDTH(PIX_W),
		.DEPTH(GROUP_COUNT)
	) u_cache (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (accept && in_range),
		.raddr(idx_s0),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == IDX_W'(GROUP_COUNT - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= in_range;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1      <= idx_s0;
			pixels_s1   <= pixels;
			redraw_s1   <= force_write;
			fwd_s1      <= s1_write && (idx_s1 == idx_s0);
			fwd_data_s1 <= pixels_s1;
		end
	end

	assign grp_valid   = valid_s1 && emit_s1;
	assign grp.offset  = VOFF_W'(idx_s1);
	assign grp.pixels  = pixels_s1;

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < 32'(GROUP_COUNT)))
		else $error("cache write beyond last entry");

	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !accept)
		else $error("item taken during clearing pass");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(idx_s1) && $stable(cached)))
		else $error("stalled lookup lost its entry or cache data");

endmodule

`default_nettype wire

[design/ptp_emit.sv]
// Plane write sequencer: holds one changed group and sends its four plane
// writes, one per transfer. Uses ptp_pkg.
`default_nettype none

module ptp_emit
	import ptp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                grp_valid,
	output logic                     grp_ready,
	input  wire ptp_group_t          grp,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [PLANE_W-1:0]       plane_index,
	output logic [VOFF_W-1:0]        video_offset,
	output logic [BYTE_W-1:0]        plane_bits,
	output logic                     last_write
);

	logic               busy_q;
	logic [PLANE_W-1:0] plane_q;
	logic [VOFF_W-1:0]  offset_q;
	logic [PIX_W-1:0]   pixels_q;
	logic               last;
	logic               out_xfer;
	logic               done;

	assign last      = plane_q == PLANE_W'(PLANES - 1);
	assign out_xfer  = busy_q && out_ready;
	assign done      = out_xfer && last;
	assign grp_ready = !busy_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			plane_q <= '0;
		end else if (grp_valid && grp_ready) begin
			busy_q  <= 1'b1;
			plane_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (out_xfer) begin
			plane_q <= plane_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			offset_q <= grp.offset;
			pixels_q <= grp.pixels;
		end
	end

	assign out_valid    = busy_q;
	assign plane_index  = plane_q;
	assign video_offset = offset_q;
	assign plane_bits   = gather_plane(pixels_q, plane_q);
	assign last_write   = last;

	a_plane_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && !last) |=> (busy_q && plane_q == $past(plane_q) + 1'b1 &&
			$stable(offset_q)))
		else $error("plane sequence skipped or group changed mid-sequence");

endmodule

`default_nettype wire
